### rtl/tdpt_pkg.sv
// Shared types and constants for the trial-division prime test.
// No dependencies; used by tdpt_rem and trial_division_prime_test_core.
`default_nettype none

package tdpt_pkg;

    // smallest prime, also the first trial divisor
    localparam int SMALLEST_PRIME = 2;

    // status returned by the remainder unit
    typedef struct packed {
        logic busy;
        logic done;      // one-cycle pulse when the remainder is ready
        logic rem_zero;  // valid with done: divisor divides the dividend
    } rem_status_t;

endpackage

`default_nettype wire

### rtl/trial_division_prime_test_core.sv
// Trial-division primality test, top level.
// Depends on tdpt_pkg and tdpt_rem.
//
// Usage:
//   Input beat: s_candidate (VALUE_WIDTH bits, unsigned) on s_valid/s_ready.
//   Result beat: m_is_prime (1 = prime) on m_valid/m_ready, one per input.
//   One candidate is worked on at a time; s_ready is high only while the
//   search engine is free. A result waits in the output register, so a new
//   candidate is taken while the previous result is still unclaimed.
//   Steps: 0 or 1 goes straight to the finish state. Otherwise divisors
//   d = 2, 3, ... are tried while d*d <= candidate; each trial is made of
//   one bound check, VALUE_WIDTH shifts of the bit-serial remainder unit
//   and its done cycle.
//   There are k trials in all; k is the smallest divisor - 1 for a
//   composite and floor(sqrt(candidate)) - 1 for a prime (worst case
//   about 2^(VALUE_WIDTH/2) trials).
//   A new candidate is taken only after the last result has moved to
//   the output register, which waits while it still holds an unclaimed one.
//   Reset (synchronous, active low) drops any item in flight and empties
//   the output register. If m_ready stays low, the finished result is held
//   and the engine waits before it can hand over the next one.
`default_nettype none

module trial_division_prime_test_core #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output      logic                   s_ready,
    input  wire logic [VALUE_WIDTH-1:0] s_candidate,
    output      logic                   m_valid,
    input  wire logic                   m_ready,
    output      logic                   m_is_prime
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_CHECK  = 4'b0010,
        ST_DIV    = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    localparam logic [VALUE_WIDTH-1:0] FirstDiv = VALUE_WIDTH'(tdpt_pkg::SMALLEST_PRIME);
    localparam logic [VALUE_WIDTH:0]   FirstSq  =
        (VALUE_WIDTH + 1)'(tdpt_pkg::SMALLEST_PRIME * tdpt_pkg::SMALLEST_PRIME);

    state_t                 state_reg, state_next;
    logic [VALUE_WIDTH-1:0] cand_reg, cand_next;
    logic [VALUE_WIDTH-1:0] d_reg, d_next;
    logic [VALUE_WIDTH:0]   sq_reg, sq_next;     // d*d, kept incrementally
    logic                   res_reg, res_next;
    logic                   m_valid_reg, m_valid_next;
    logic                   m_prime_reg, m_prime_next;
    logic                   rem_start;
    tdpt_pkg::rem_status_t  rem_st;

    tdpt_rem #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_rem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (rem_start),
        .dividend (cand_reg),
        .divisor  (d_reg),
        .status   (rem_st)
    );

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next   = state_reg;
        cand_next    = cand_reg;
        d_next       = d_reg;
        sq_next      = sq_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg;
        m_prime_next = m_prime_reg;
        rem_start    = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cand_next = s_candidate;
                    d_next    = FirstDiv;
                    sq_next   = FirstSq;
                    if (s_candidate < FirstDiv) begin
                        res_next   = 1'b0;
                        state_next = ST_FINISH;
                    end else begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                // no divisor up to sqrt: prime
                if (sq_reg > {1'b0, cand_reg}) begin
                    res_next   = 1'b1;
                    state_next = ST_FINISH;
                end else begin
                    rem_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (rem_st.done) begin
                    if (rem_st.rem_zero) begin
                        res_next   = 1'b0;
                        state_next = ST_FINISH;
                    end else begin
                        // (d+1)^2 = d^2 + 2d + 1
                        sq_next    = sq_reg + {d_reg, 1'b1};
                        d_next     = d_reg + VALUE_WIDTH'(1);
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_prime_next = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        cand_reg    <= cand_next;
        d_reg       <= d_next;
        sq_reg      <= sq_next;
        res_reg     <= res_next;
        m_prime_reg <= m_prime_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_is_prime = m_prime_reg;

`ifndef NO_ASSERTIONS
    // remainder unit is only started when idle
    a_rem_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        rem_start |-> !rem_st.busy)
        else $error("remainder unit restarted while busy");

    // a prime verdict is never given for a value below two
    a_prime_ge_two: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH && res_reg) |-> (cand_reg >= FirstDiv))
        else $error("prime verdict for value below two");

    // a completed trial always comes while waiting in ST_DIV
    a_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        rem_st.done |-> (state_reg == ST_DIV))
        else $error("remainder done outside divide state");

    // trial divisor never drops below the smallest prime
    a_div_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CHECK) |-> (d_reg >= FirstDiv))
        else $error("trial divisor below two");
`endif

endmodule

`default_nettype wire

### rtl/tdpt_rem.sv
// Bit-serial restoring remainder unit: one dividend bit per cycle.
// Depends on tdpt_pkg (rem_status_t).
`default_nettype none

module tdpt_rem #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   start,
    input  wire logic [VALUE_WIDTH-1:0] dividend,
    input  wire logic [VALUE_WIDTH-1:0] divisor,
    output tdpt_pkg::rem_status_t       status
);

    localparam int CntW = $clog2(VALUE_WIDTH + 1);

    logic [VALUE_WIDTH-1:0] shift_reg, shift_next;
    logic [VALUE_WIDTH-1:0] rem_reg, rem_next;
    logic [VALUE_WIDTH-1:0] div_reg, div_next;
    logic [CntW-1:0]        cnt_reg, cnt_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic                   zero_reg, zero_next;

    logic [VALUE_WIDTH:0]   trial;
    logic [VALUE_WIDTH:0]   diff;
    logic [VALUE_WIDTH-1:0] rem_step;

    // remainder stays below divisor, so the shifted value fits W+1 bits;
    // the top bit of the difference is the borrow
    always_comb begin
        trial    = {rem_reg, shift_reg[VALUE_WIDTH-1]};
        diff     = trial - {1'b0, div_reg};
        rem_step = diff[VALUE_WIDTH] ? trial[VALUE_WIDTH-1:0]
                                     : diff[VALUE_WIDTH-1:0];
    end

    always_comb begin
        shift_next = shift_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        zero_next  = zero_reg;
        if (start) begin
            shift_next = dividend;
            rem_next   = '0;
            div_next   = divisor;
            cnt_next   = CntW'(VALUE_WIDTH);
            busy_next  = 1'b1;
        end else if (busy_reg) begin
            shift_next = {shift_reg[VALUE_WIDTH-2:0], 1'b0};
            rem_next   = rem_step;
            cnt_next   = cnt_reg - CntW'(1);
            if (cnt_reg == CntW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
                zero_next = (rem_step == '0);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
        div_reg   <= div_next;
        zero_reg  <= zero_next;
    end

    assign status.busy     = busy_reg;
    assign status.done     = done_reg;
    assign status.rem_zero = zero_reg;

endmodule

`default_nettype wire
